@@ src/ssv_pkg.sv @@
// ----------------------------------------------------------------------------
// ssv_pkg
// Shared types, codes and helpers for the shared slot store.
// ----------------------------------------------------------------------------
package ssv_pkg;

  localparam int SLOT_COUNT    = 1024;
  localparam int SLOT_W        = 10;
  localparam int PTR_W         = 11;
  localparam int MAX_CONSUMERS = 16;
  localparam int CONS_W        = 4;
  localparam int USAGE_W       = 2 * MAX_CONSUMERS;
  localparam int COUNT_W       = 16;
  localparam int ACT_W         = 5;

  // Null link value.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOT_COUNT);

  // Command codes.
  localparam logic [2:0] CMD_ALLOC      = 3'd0;
  localparam logic [2:0] CMD_ADD_REF    = 3'd1;
  localparam logic [2:0] CMD_DROP_REF   = 3'd2;
  localparam logic [2:0] CMD_MARK_INS   = 3'd3;
  localparam logic [2:0] CMD_MARK_DEL   = 3'd4;
  localparam logic [2:0] CMD_SCAN_START = 3'd5;
  localparam logic [2:0] CMD_SCAN_NEXT  = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // Configuration register byte address.
  localparam logic [2:0] REG_ACTIVE_CONSUMERS = 3'd0;

  typedef struct packed {
    logic [2:0]         command;
    logic [SLOT_W-1:0]  slot;
    logic [CONS_W-1:0]  consumer;
    logic [COUNT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] result_slot;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic rd_op;
    logic exec;
    logic link;
    logic seek_rd;
    logic seek_ev;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic go_link;
    logic go_seek;
    logic p_nil;
    logic seek_hit;
    logic out_busy;
  } stat_t;

  // Usage bits for a freshly allocated slot: insert and delete bits for every
  // active consumer, with the count clamped to the legal range.
  function automatic logic [USAGE_W-1:0] initial_usage(input logic [ACT_W-1:0] n);
    logic [ACT_W-1:0]         m;
    logic [MAX_CONSUMERS-1:0] low;
    m = n;
    if (m == '0) begin
      m = ACT_W'(1);
    end
    if (m >= ACT_W'(MAX_CONSUMERS)) begin
      low = '1;
    end else begin
      low = MAX_CONSUMERS'((32'd1 << m) - 32'd1);
    end
    return {low, low};
  endfunction

endpackage

@@ src/ssv_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssv_ctrl
// Sequencer for the shared slot store: read, execute, link and list walk.
// ----------------------------------------------------------------------------
module ssv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ssv_pkg::stat_t stat,
  output ssv_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_LINK    = 3'd3;
  localparam logic [2:0] S_SEEK_RD = 3'd4;
  localparam logic [2:0] S_SEEK_EV = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign cmd_stall = (state != S_IDLE) || stat.out_busy;

  always_comb begin
    ctrl         = '0;
    ctrl.rd_op   = (state == S_READ);
    ctrl.exec    = (state == S_EXEC);
    ctrl.link    = (state == S_LINK);
    ctrl.seek_rd = (state == S_SEEK_RD);
    ctrl.seek_ev = (state == S_SEEK_EV);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && !cmd_stall) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.go_link) begin
          state_next = S_LINK;
        end else if (stat.go_seek) begin
          state_next = S_SEEK_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        state_next = S_IDLE;
      end
      S_SEEK_RD: begin
        state_next = stat.p_nil ? S_IDLE : S_SEEK_EV;
      end
      S_SEEK_EV: begin
        state_next = stat.seek_hit ? S_IDLE : S_SEEK_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/ssv_datapath.sv @@
// ----------------------------------------------------------------------------
// ssv_datapath
// Slot memories, list heads, scan cursors and the result register.
// ----------------------------------------------------------------------------
module ssv_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  ssv_pkg::ctrl_t              ctrl,
  input  logic                        load,
  input  ssv_pkg::cmd_t               cmd,
  input  logic [ssv_pkg::ACT_W-1:0]   active_consumers,
  input  logic                        rsp_stall,
  output logic                        rsp_valid,
  output ssv_pkg::rsp_t               rsp,
  output ssv_pkg::stat_t              stat
);

  localparam int SW = ssv_pkg::SLOT_W;
  localparam int PW = ssv_pkg::PTR_W;
  localparam int UW = ssv_pkg::USAGE_W;
  localparam int CW = ssv_pkg::COUNT_W;
  localparam int MC = ssv_pkg::MAX_CONSUMERS;

  // Slot memories.
  logic [PW-1:0] mem_next  [ssv_pkg::SLOT_COUNT];
  logic [PW-1:0] mem_prev  [ssv_pkg::SLOT_COUNT];
  logic [UW-1:0] mem_usage [ssv_pkg::SLOT_COUNT];
  logic [CW-1:0] mem_count [ssv_pkg::SLOT_COUNT];

  logic [PW-1:0] rd_next;
  logic [PW-1:0] rd_prev;
  logic [UW-1:0] rd_usage;
  logic [CW-1:0] rd_count;

  logic [PW-1:0] live_head;
  logic [PW-1:0] free_head;
  logic [PW-1:0] high_water;
  logic [PW-1:0] cursor [MC];

  ssv_pkg::cmd_t op;
  logic [PW-1:0] p;
  logic [PW-1:0] steps;
  logic [SW-1:0] rs;

  logic [SW-1:0] raddr;

  logic          we_next, we_prev, we_usage, we_count;
  logic [SW-1:0] wa_next, wa_prev, wa_usage, wa_count;
  logic [PW-1:0] wd_next, wd_prev;
  logic [UW-1:0] wd_usage;
  logic [CW-1:0] wd_count;

  logic          slot_ok, bad, full, from_free;
  logic [SW-1:0] alloc_n;
  logic [CW:0]   sum;
  logic          u_ins, u_del, seen, steps_max, unlink;
  logic [UW-1:0] usage_clr_del;
  logic [PW-1:0] cur;
  logic [1:0]    ex_status;
  logic [SW-1:0] ex_rs;
  logic          go_link, go_seek, done;

  always_comb begin
    cur           = cursor[op.consumer];
    slot_ok       = ({1'b0, op.slot} < high_water) && (rd_count != '0);
    from_free     = free_head != ssv_pkg::NIL;
    full          = !from_free && (high_water == ssv_pkg::NIL);
    alloc_n       = from_free ? free_head[SW-1:0] : high_water[SW-1:0];
    sum           = {1'b0, rd_count} + {1'b0, op.amount};
    // Insert bits sit in the low half, delete bits in the high half.
    u_ins         = rd_usage[{1'b0, op.consumer}];
    u_del         = rd_usage[{1'b1, op.consumer}];
    seen          = u_del && !u_ins;
    usage_clr_del = rd_usage & ~(UW'(1) << (UW'(op.consumer) + UW'(MC)));
    unlink        = usage_clr_del == '0;
    steps_max     = steps == PW'(ssv_pkg::SLOT_COUNT);
  end

  // Outcome of the execute step.
  always_comb begin
    bad       = 1'b0;
    go_link   = 1'b0;
    go_seek   = 1'b0;
    ex_status = ssv_pkg::ST_OK;
    ex_rs     = '0;
    case (op.command)
      ssv_pkg::CMD_ALLOC: begin
        if (full) begin
          ex_status = ssv_pkg::ST_FULL;
        end else begin
          ex_rs   = alloc_n;
          go_link = live_head != ssv_pkg::NIL;
        end
      end
      ssv_pkg::CMD_ADD_REF:  bad = !slot_ok || sum[CW];
      ssv_pkg::CMD_DROP_REF: bad = !slot_ok || (rd_count == CW'(1) && rd_usage != '0);
      ssv_pkg::CMD_MARK_INS: bad = !slot_ok || !u_ins;
      ssv_pkg::CMD_MARK_DEL: bad = !slot_ok || u_ins || !u_del;
      ssv_pkg::CMD_SCAN_START: go_seek = 1'b1;
      ssv_pkg::CMD_SCAN_NEXT: begin
        if (cur == ssv_pkg::NIL) begin
          ex_status = ssv_pkg::ST_END;
        end else begin
          go_seek = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      ex_status = ssv_pkg::ST_BAD;
    end
  end

  always_comb begin
    stat          = '0;
    stat.go_link  = go_link;
    stat.go_seek  = go_seek;
    stat.p_nil    = p == ssv_pkg::NIL;
    stat.seek_hit = seen || steps_max;
    stat.out_busy = rsp_valid && rsp_stall;
  end

  assign done = (ctrl.exec && !go_link && !go_seek) || ctrl.link ||
                (ctrl.seek_rd && stat.p_nil) || (ctrl.seek_ev && stat.seek_hit);

  // Read address.
  always_comb begin
    raddr = op.slot;
    if (ctrl.rd_op) begin
      case (op.command)
        ssv_pkg::CMD_ALLOC:     raddr = free_head[SW-1:0];
        ssv_pkg::CMD_SCAN_NEXT: raddr = cur[SW-1:0];
        default:                raddr = op.slot;
      endcase
    end else if (ctrl.seek_rd) begin
      raddr = p[SW-1:0];
    end
  end

  // Memory writes.
  always_comb begin
    we_next  = 1'b0; wa_next  = op.slot; wd_next  = free_head;
    we_prev  = 1'b0; wa_prev  = op.slot; wd_prev  = ssv_pkg::NIL;
    we_usage = 1'b0; wa_usage = op.slot; wd_usage = usage_clr_del;
    we_count = 1'b0; wa_count = op.slot; wd_count = sum[CW-1:0];
    if (ctrl.exec && !bad) begin
      case (op.command)
        ssv_pkg::CMD_ALLOC: begin
          if (!full) begin
            we_usage = 1'b1; wa_usage = alloc_n;
            wd_usage = ssv_pkg::initial_usage(active_consumers);
            we_count = 1'b1; wa_count = alloc_n; wd_count = CW'(1);
            we_next  = 1'b1; wa_next  = alloc_n; wd_next  = live_head;
            we_prev  = 1'b1; wa_prev  = alloc_n; wd_prev  = ssv_pkg::NIL;
          end
        end
        ssv_pkg::CMD_ADD_REF: begin
          we_count = 1'b1;
        end
        ssv_pkg::CMD_DROP_REF: begin
          we_count = 1'b1;
          wd_count = rd_count - CW'(1);
          we_next  = rd_count == CW'(1);
        end
        ssv_pkg::CMD_MARK_INS: begin
          we_usage = 1'b1;
          wd_usage = rd_usage & ~(UW'(1) << op.consumer);
        end
        ssv_pkg::CMD_MARK_DEL: begin
          we_usage = 1'b1;
          if (unlink) begin
            we_prev = rd_next != ssv_pkg::NIL;
            wa_prev = rd_next[SW-1:0];
            wd_prev = rd_prev;
            we_next = rd_prev != ssv_pkg::NIL;
            wa_next = rd_prev[SW-1:0];
            wd_next = rd_next;
          end
        end
        default: begin
        end
      endcase
    end else if (ctrl.link) begin
      we_prev = 1'b1;
      wa_prev = live_head[SW-1:0];
      wd_prev = {1'b0, rs};
    end
  end

  always_ff @(posedge clk) begin
    rd_next  <= mem_next[raddr];
    rd_prev  <= mem_prev[raddr];
    rd_usage <= mem_usage[raddr];
    rd_count <= mem_count[raddr];
    if (we_next)  mem_next[wa_next]   <= wd_next;
    if (we_prev)  mem_prev[wa_prev]   <= wd_prev;
    if (we_usage) mem_usage[wa_usage] <= wd_usage;
    if (we_count) mem_count[wa_count] <= wd_count;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      live_head  <= ssv_pkg::NIL;
      free_head  <= ssv_pkg::NIL;
      high_water <= '0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < MC; i++) begin
        cursor[i] <= ssv_pkg::NIL;
      end
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (done) begin
        rsp_valid <= 1'b1;
      end
      if (ctrl.exec && !bad) begin
        case (op.command)
          ssv_pkg::CMD_ALLOC: begin
            if (!full) begin
              if (from_free) begin
                free_head <= rd_next;
              end else begin
                high_water <= high_water + PW'(1);
              end
              if (live_head == ssv_pkg::NIL) begin
                live_head <= {1'b0, alloc_n};
              end
            end
          end
          ssv_pkg::CMD_DROP_REF: begin
            if (rd_count == CW'(1)) begin
              free_head <= {1'b0, op.slot};
            end
          end
          ssv_pkg::CMD_MARK_DEL: begin
            if (unlink && rd_prev == ssv_pkg::NIL) begin
              live_head <= rd_next;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctrl.link) begin
        live_head <= {1'b0, rs};
      end
      if (ctrl.seek_rd && stat.p_nil) begin
        cursor[op.consumer] <= ssv_pkg::NIL;
      end
      if (ctrl.seek_ev && stat.seek_hit) begin
        cursor[op.consumer] <= seen ? p : ssv_pkg::NIL;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      op <= cmd;
    end
    if (ctrl.exec) begin
      rs    <= ex_rs;
      steps <= '0;
      if (op.command == ssv_pkg::CMD_SCAN_NEXT) begin
        rs <= cur[SW-1:0];
        p  <= rd_next;
      end else begin
        p  <= live_head;
      end
    end
    if (ctrl.seek_ev && !stat.seek_hit) begin
      p     <= rd_next;
      steps <= steps + PW'(1);
    end
    if (done) begin
      if (ctrl.exec) begin
        rsp.status      <= ex_status;
        rsp.result_slot <= ex_rs;
      end else begin
        rsp.status      <= ssv_pkg::ST_OK;
        rsp.result_slot <= rs;
      end
    end
  end

endmodule

@@ src/shared_slot_store_visibility.sv @@
// ----------------------------------------------------------------------------
// shared_slot_store_visibility
// Reference-counted slot pool with a free list, a doubly linked live list and
// per-consumer visibility bits with scan cursors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   cmd       in         cmd_valid / cmd_stall     ssv_pkg::cmd_t
//   rsp       out        rsp_valid / rsp_stall     ssv_pkg::rsp_t
//   apb       in         psel/penable/pwrite       active_consumers at 0x0
//
// Every command produces exactly one response transaction. A command is read
// from the slot memories in the read state and executed in the execute state.
// Allocate onto a non-empty live list adds a link state, because the old
// head's back link is written there on the single prev-link write port. Scans
// walk the live list with one memory read and one check per visited slot,
// bounded by SLOT_COUNT steps. Reset is synchronous; it empties both lists,
// clears the high-water count and parks every cursor at null. No memory
// clearing pass is needed. A held response blocks new commands until it is
// taken.
//
module shared_slot_store_visibility (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ssv_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ssv_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  ssv_pkg::ctrl_t ctrl;
  ssv_pkg::stat_t stat;
  logic [ssv_pkg::ACT_W-1:0] active_consumers;

  // The single configuration register is written on the APB access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_consumers <= ssv_pkg::ACT_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 paddr == ssv_pkg::REG_ACTIVE_CONSUMERS) begin
      active_consumers <= pwdata[ssv_pkg::ACT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ssv_pkg::REG_ACTIVE_CONSUMERS) begin
      prdata = {{(32 - ssv_pkg::ACT_W){1'b0}}, active_consumers};
    end
  end

  // The controller sequences each command; the datapath owns all storage.
  ssv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  ssv_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .load             (cmd_valid && !cmd_stall),
    .cmd              (cmd),
    .active_consumers (active_consumers),
    .rsp_stall        (rsp_stall),
    .rsp_valid        (rsp_valid),
    .rsp              (rsp),
    .stat             (stat)
  );

endmodule

@@ tb/sv/ssv_checker.sv @@
// ----------------------------------------------------------------------------
// ssv_checker
// Watches the command and response channels of the slot store, predicts each
// response from a behavioral copy of the store state, and counts mismatches.
// ----------------------------------------------------------------------------
module ssv_checker
  import ssv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_t                  cmd,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output int                    fail_count,
  output int                    pending,
  output logic [PTR_W-1:0]      hw_mirror,
  output logic [COUNT_W-1:0]    cnt_mirror [SLOT_COUNT],
  output logic [USAGE_W-1:0]    use_mirror [SLOT_COUNT]
);

  logic [PTR_W-1:0]   nxt [SLOT_COUNT];
  logic [PTR_W-1:0]   prv [SLOT_COUNT];
  logic [PTR_W-1:0]   live_top, free_top, high_mark;
  logic [PTR_W-1:0]   cursor [MAX_CONSUMERS];
  logic [ACT_W-1:0]   consumers;
  rsp_t               awaited [$];

  assign hw_mirror = high_mark;

  function automatic logic [USAGE_W-1:0] fresh_usage();
    int n;
    logic [15:0] low;
    n = consumers;
    if (n < 1) n = 1;
    if (n > MAX_CONSUMERS) n = MAX_CONSUMERS;
    low = (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
    return {low, low};
  endfunction

  function automatic bit visible_to(int s, int c);
    return use_mirror[s][c] == 1'b0 && use_mirror[s][16+c] == 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] next_visible(logic [PTR_W-1:0] p, int c);
    int steps;
    steps = 0;
    while (p < NIL && !visible_to(p, c)) begin
      if (steps >= SLOT_COUNT) return NIL;
      p = nxt[p];
      steps++;
    end
    return p;
  endfunction

  // Applies one command to the shadow store and returns its response.
  function automatic rsp_t store_response(cmd_t t);
    rsp_t r;
    int s, c;
    bit held, c_ok;
    logic [PTR_W-1:0] n, nx, pv;
    r = '0;
    r.status = ST_OK;
    s = t.slot;
    c = t.consumer;
    held = (s < high_mark) && (cnt_mirror[s] > 0);
    c_ok = c < MAX_CONSUMERS;
    case (t.command)
      CMD_ALLOC: begin
        if (free_top < NIL) begin
          n = free_top;
          free_top = nxt[n];
        end else if (high_mark < NIL) begin
          n = high_mark;
          high_mark++;
        end else begin
          r.status = ST_FULL;
          return r;
        end
        use_mirror[n] = fresh_usage();
        cnt_mirror[n] = COUNT_W'(1);
        nxt[n] = live_top;
        if (live_top < NIL) prv[live_top] = n;
        prv[n] = NIL;
        live_top = n;
        r.result_slot = n[SLOT_W-1:0];
      end
      CMD_ADD_REF: begin
        if (!held || 32'(cnt_mirror[s]) + 32'(t.amount) > 32'hFFFF) r.status = ST_BAD;
        else cnt_mirror[s] += t.amount;
      end
      CMD_DROP_REF: begin
        if (!held || (cnt_mirror[s] == 1 && use_mirror[s] != 0)) r.status = ST_BAD;
        else begin
          cnt_mirror[s]--;
          if (cnt_mirror[s] == 0) begin
            nxt[s] = free_top;
            free_top = PTR_W'(s);
          end
        end
      end
      CMD_MARK_INS: begin
        if (!held || !c_ok || !use_mirror[s][c]) r.status = ST_BAD;
        else use_mirror[s][c] = 1'b0;
      end
      CMD_MARK_DEL: begin
        if (!held || !c_ok || use_mirror[s][c] || !use_mirror[s][16+c]) r.status = ST_BAD;
        else begin
          use_mirror[s][16+c] = 1'b0;
          if (use_mirror[s] == 0) begin
            nx = nxt[s];
            pv = prv[s];
            if (nx < NIL) prv[nx] = pv;
            if (pv < NIL) nxt[pv] = nx;
            else live_top = nx;
          end
        end
      end
      CMD_SCAN_START: begin
        if (!c_ok) r.status = ST_BAD;
        else cursor[c] = next_visible(live_top, c);
      end
      CMD_SCAN_NEXT: begin
        if (!c_ok) r.status = ST_BAD;
        else if (cursor[c] >= NIL) r.status = ST_END;
        else begin
          r.result_slot = cursor[c][SLOT_W-1:0];
          cursor[c] = next_visible(nxt[cursor[c]], c);
        end
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        nxt[i] = '0; prv[i] = '0; cnt_mirror[i] = '0; use_mirror[i] = '0;
      end
      for (int i = 0; i < MAX_CONSUMERS; i++) cursor[i] = NIL;
      live_top = NIL;
      free_top = NIL;
      high_mark = '0;
      consumers = ACT_W'(1);
      awaited.delete();
      pending = 0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_ACTIVE_CONSUMERS)
        consumers = pwdata[ACT_W-1:0];
      // Responses are checked before the command of the same edge is applied;
      // a response can never belong to a command accepted at the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response %p", rsp);
        end else begin
          want = awaited.pop_front();
          if (rsp.status !== want.status || rsp.result_slot !== want.result_slot) begin
            fail_count++;
            if (fail_count <= 10)
              $display("response mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                       want.status, want.result_slot, rsp.status, rsp.result_slot);
          end
        end
      end
      if (cmd_valid && !cmd_stall) awaited.push_back(store_response(cmd));
      pending = awaited.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the shared slot store: directed corner cases, then
// mostly well-formed slot lifecycles with random noise, under three idling
// regimes and several consumer counts. Checking is done by ssv_checker.
// ----------------------------------------------------------------------------
module tb;
  import ssv_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int                 fail_count, pending;
  logic [PTR_W-1:0]   high_mark;
  logic [COUNT_W-1:0] counts [SLOT_COUNT];
  logic [USAGE_W-1:0] usage [SLOT_COUNT];

  // Idle probabilities in percent for each side.
  int send_idle = 0, recv_idle = 0;
  int quiet_cycles = 0;
  logic [ACT_W-1:0] consumers_now = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shared_slot_store_visibility i_dut (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ssv_checker i_check (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count, .pending, .hw_mirror(high_mark), .cnt_mirror(counts),
    .use_mirror(usage)
  );

  // The receiver stalls at random; a new draw is made at every falling edge.
  always @(negedge clk) begin
    if (!rst) rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  // Watchdog: cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one command: optional random gap, then hold valid until accepted.
  // Valid stays high after acceptance; the caller either sends the next
  // command or drops valid at the same falling edge, before the next rising
  // edge can see it.
  task automatic send(input cmd_t t);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= t;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic issue(input logic [2:0] op, input int s, input int c, input int amt);
    cmd_t t;
    t.command = op;
    t.slot = SLOT_W'(s);
    t.consumer = CONS_W'(c);
    t.amount = COUNT_W'(amt);
    send(t);
  endtask

  // Stops sending and waits until every response has come.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_consumers(input int n);
    consumers_now = ACT_W'(n);
    paddr <= REG_ACTIVE_CONSUMERS;
    pwdata <= 32'(n);
    psel <= 1'b1;
    pwrite <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Picks a slot that is known to be held, or a random index if eight tries find none.
  function automatic int held_slot();
    for (int k = 0; k < 8; k++) begin
      int s;
      s = $urandom_range(high_mark > 0 ? high_mark - 1 : 0);
      if (s < high_mark && counts[s] != 0) return s;
    end
    return high_mark > 0 ? $urandom_range(high_mark - 1) : 0;
  endfunction

  // One random command. Most are legal lifecycle steps on held slots;
  // the rest are random noise that the block may accept or reject.
  task automatic random_command();
    int pick, s, c, act, rnd_slot;
    pick = $urandom_range(99);
    s = held_slot();
    act = consumers_now == 0 ? 1 : (consumers_now > 16 ? 16 : consumers_now);
    c = $urandom_range(act - 1);
    // Random slots mostly fall below the high-water mark; the others fail the
    // high-water check of slot commands before any stored entry decides the outcome.
    rnd_slot = (high_mark > 0 && $urandom_range(3) != 0) ? $urandom_range(high_mark - 1)
                                                         : $urandom_range(1023);
    if (rnd_slot >= high_mark && high_mark > 0) rnd_slot = $urandom_range(1023);
    if (pick < 14) issue(CMD_ALLOC, $urandom_range(1023), $urandom_range(15), $urandom);
    else if (pick < 34) begin
      // Pick a consumer whose insert bit is still set, when one is.
      for (int k = 0; k < act; k++)
        if (usage[s][k]) begin c = k; break; end
      issue(CMD_MARK_INS, s, c, $urandom);
    end else if (pick < 54) begin
      for (int k = 0; k < act; k++)
        if (!usage[s][k] && usage[s][16+k]) begin c = k; break; end
      issue(CMD_MARK_DEL, s, c, $urandom);
    end else if (pick < 60) issue(CMD_ADD_REF, s, 0, $urandom_range(3));
    else if (pick < 68) issue(CMD_DROP_REF, s, 0, $urandom);
    else if (pick < 72) issue(CMD_SCAN_START, 0, c, $urandom);
    else if (pick < 86) issue(CMD_SCAN_NEXT, 0, c, $urandom);
    else begin
      cmd_t t;
      t = cmd_t'($urandom);
      t.slot = SLOT_W'(rnd_slot);
      send(t);
    end
  endtask

  initial begin
    int cfgs [4] = '{16, 1, 0, 31};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty store, extremes of every field, each rejection rule.
    write_consumers(2);
    issue(CMD_SCAN_NEXT, 0, 0, 0);          // cursor null: scan ended
    issue(CMD_ADD_REF, 0, 0, 1);            // slot never allocated
    issue(CMD_ALLOC, 1023, 15, 16'hFFFF);   // slot 0
    issue(CMD_ALLOC, 0, 0, 0);              // slot 1
    issue(CMD_ADD_REF, 0, 0, 16'hFFFF);     // count overflow
    issue(CMD_ADD_REF, 0, 0, 0);            // zero amount is fine
    issue(CMD_ADD_REF, 0, 0, 16'hFFFE);     // count at 65535
    issue(CMD_MARK_DEL, 0, 0, 0);           // delete before insert
    issue(CMD_MARK_INS, 0, 0, 0);
    issue(CMD_MARK_INS, 0, 0, 0);           // insert bit already clear
    issue(CMD_SCAN_START, 0, 0, 0);
    issue(CMD_SCAN_NEXT, 0, 0, 0);
    issue(CMD_SCAN_NEXT, 0, 0, 0);
    issue(CMD_MARK_INS, 0, 15, 0);          // inactive consumer bit is clear
    issue(CMD_SCAN_START, 0, 15, 0);
    issue(CMD_DROP_REF, 1, 0, 0);           // freeing a slot still in use
    issue(CMD_MARK_INS, 1, 0, 0);
    issue(CMD_MARK_INS, 1, 1, 0);
    issue(CMD_MARK_DEL, 1, 0, 0);
    issue(CMD_MARK_DEL, 1, 1, 0);           // unlinks slot 1
    issue(CMD_MARK_DEL, 1, 1, 0);           // delete bit already clear
    issue(CMD_DROP_REF, 1, 0, 0);           // frees slot 1
    issue(CMD_DROP_REF, 1, 0, 0);           // slot no longer held
    issue(CMD_ALLOC, 0, 0, 0);              // reuses slot 1 from the free list
    send(cmd_t'({3'd7, 30'h3FFFFFFF}));     // unused command
    drain();

    // Random phases over several consumer counts and idling regimes. The
    // final fill supplies most of the item count, so these stay short.
    for (int ph = 0; ph < 4; ph++) begin
      write_consumers(cfgs[ph]);
      if (ph == 0) begin send_idle = 14; recv_idle = 61; end
      else if (ph == 1) begin send_idle = 61; recv_idle = 14; end
      else begin send_idle = 0; recv_idle = 0; end
      for (int i = 0; i < 72; i++) begin
        random_command();
        if (i == 36) begin
          cmd_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end

    // Fill the store completely to reach the full status.
    write_consumers(1);
    while (high_mark < NIL) issue(CMD_ALLOC, 0, 0, 0);
    issue(CMD_ALLOC, 0, 0, 0);
    issue(CMD_ALLOC, 0, 0, 0);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
